FILE: src/bpsc_pkg.sv
`default_nettype none

package bpsc_pkg;

  localparam int unsigned DEPTH_LOG2_DEF = 12;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PLANES = 8;
  localparam int unsigned PERM_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = SIZE_W'(12);

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_VALUE_SEED   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_BIT_REF_SEED = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_INDEX_MASK   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_MASKS_LO     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_MASKS_HI     = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_SIZE_LOG2    = IDX_W'(5);

  typedef enum logic [REQ_W-1:0] {
    REQ_ENCRYPT   = 2'd0,
    REQ_DECRYPT   = 2'd1,
    REQ_RAW_WRITE = 2'd2,
    REQ_RAW_READ  = 2'd3
  } req_e;

  // Per-request control shared by all plane lanes.
  typedef struct packed {
    logic en;
    logic we;
    logic raw;
  } lane_ctl_t;

  // 64-bit xorshift step used for both the value mask and the bit permutation.
  function automatic logic [CFG_W-1:0] mix64(input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0] t;
    t = n ^ (n << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: src/bpsc_ram.sv
`default_nettype none

module bpsc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/bpsc_lane.sv
`default_nettype none

module bpsc_lane #(
  parameter int unsigned DEPTH_LOG2 = bpsc_pkg::DEPTH_LOG2_DEF,
  parameter int unsigned LANE       = 0
) (
  input  wire logic                               clk_i,
  input  wire bpsc_pkg::lane_ctl_t                ctl_i,
  input  wire logic [DEPTH_LOG2-1:0]              base_i,
  input  wire logic [DEPTH_LOG2-1:0]              raw_addr_i,
  input  wire logic [DEPTH_LOG2-1:0]              amask_i,
  input  wire logic [DEPTH_LOG2-1:0]              plane_mask_i,
  input  wire logic [bpsc_pkg::BYTE_W-1:0]        wbyte_i,
  input  wire logic [bpsc_pkg::PERM_W-1:0]        perm_i,
  output logic                                    rbit_o
);

  import bpsc_pkg::*;

  logic [DEPTH_LOG2-1:0] scat_addr;
  logic [DEPTH_LOG2-1:0] addr;
  logic                  wbit;

  // Plane LANE lands at an offset from the base, scrambled by its own mask.
  assign scat_addr = ((base_i + DEPTH_LOG2'(LANE)) ^ plane_mask_i) & amask_i;
  assign addr      = ctl_i.raw ? raw_addr_i : scat_addr;
  assign wbit      = wbyte_i[PERM_W'(LANE) ^ perm_i];

  bpsc_ram #(
    .WIDTH (1),
    .DEPTH (1 << DEPTH_LOG2)
  ) u_plane (
    .clk_i   (clk_i),
    .en_i    (ctl_i.en),
    .we_i    (ctl_i.we),
    .addr_i  (addr),
    .wdata_i (wbit),
    .rdata_o (rbit_o)
  );

endmodule

`default_nettype wire

FILE: src/bpsc_merge.sv
`default_nettype none

module bpsc_merge (
  input  wire logic [bpsc_pkg::BYTE_W-1:0] planes_i,
  input  wire logic                        raw_i,
  input  wire logic [bpsc_pkg::PERM_W-1:0] perm_i,
  input  wire logic [bpsc_pkg::BYTE_W-1:0] vmask_i,
  output logic      [bpsc_pkg::BYTE_W-1:0] byte_o
);

  import bpsc_pkg::*;

  logic [BYTE_W-1:0] unperm;

  // Plane b carries bit (b ^ perm) of the masked byte, so bit k comes from plane k ^ perm.
  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      unperm[k] = planes_i[PERM_W'(k) ^ perm_i];
    end
  end

  assign byte_o = raw_i ? planes_i : (unperm ^ vmask_i);

endmodule

`default_nettype wire

FILE: src/bitplane_scatter_cipher.sv
`default_nettype none

// Byte buffer of 2**DEPTH_LOG2 entries stored as eight one-bit plane memories. An encrypt
// request masks the byte, permutes its bits and scatters each bit to its own plane at a
// plane-specific address; a decrypt request gathers and undoes this. Raw write and raw read
// move a whole cipher byte at one address. A request is accepted only while the block is idle.
// Its result passes the hash step (two 64-bit adds and xorshifts), the plane memory access
// and the merge into the output register, and the next request is accepted only after the
// result is loaded. A request whose position is not below the buffer size skips the memory
// step. Either way, the result waits in the merge step while the output register still holds
// a result that is not being accepted. A request whose position is out of range returns
// status 1 and data 0 and touches nothing. The user must write configuration only while the
// block is idle; the block itself does not enforce this. The plane memories have no reset;
// reading an entry never written returns undefined data.
module bitplane_scatter_cipher #(
  parameter int unsigned DEPTH_LOG2 = bpsc_pkg::DEPTH_LOG2_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic [bpsc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bpsc_pkg::CFG_W-1:0]   cfg_wdata_i,
  // Request stream.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,  // position[11:0], data_in[19:12]
  input  wire logic [bpsc_pkg::REQ_W-1:0]   s_axis_tuser,  // req_type[1:0]
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [bpsc_pkg::BYTE_W-1:0]       m_axis_tdata,  // data_out[7:0]
  output logic                              m_axis_tuser   // status
);

  import bpsc_pkg::*;

  localparam int unsigned AW = DEPTH_LOG2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_MEM  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0]  value_seed_q, bit_ref_seed_q, masks_lo_q, masks_hi_q;
  logic [MASK_W-1:0] index_mask_q;
  logic [SIZE_W-1:0] size_log2_q;

  // Request registers.
  req_e              req_q;
  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] din_q;
  logic [BYTE_W-1:0] vmask_q;
  logic [PERM_W-1:0] perm_q;
  logic [AW-1:0]     base_q;
  logic [AW-1:0]     raw_addr_q;
  logic              err_q;

  // Output register.
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_status_q;

  logic [SIZE_W:0]   eff_size;
  logic [AW-1:0]     amask;
  logic [AW-1:0]     pos_aw;
  logic              pos_err;
  logic [CFG_W-1:0]  vmix, pmix;
  logic              is_raw, is_read;
  logic              in_fire, out_free;
  lane_ctl_t         lane_ctl;
  logic [BYTE_W-1:0] wbyte;
  logic [PERM_W-1:0] lane_perm;
  logic [BYTE_W-1:0] planes;
  logic [BYTE_W-1:0] merged;
  logic [MASK_W-1:0] plane_mask [PLANES];

  assign eff_size = ((SIZE_W + 1)'(size_log2_q) > (SIZE_W + 1)'(DEPTH_LOG2)) ?
                    (SIZE_W + 1)'(DEPTH_LOG2) : (SIZE_W + 1)'(size_log2_q);
  assign amask    = ~({AW{1'b1}} << eff_size);
  assign pos_aw   = AW'(pos_q);
  assign pos_err  = (pos_q >> eff_size) != '0;
  assign vmix     = mix64(CFG_W'(pos_q) + value_seed_q);
  assign pmix     = mix64(CFG_W'(pos_q) + bit_ref_seed_q);

  assign is_raw  = (req_q == REQ_RAW_WRITE) || (req_q == REQ_RAW_READ);
  assign is_read = (req_q == REQ_DECRYPT) || (req_q == REQ_RAW_READ);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        state_d = pos_err ? ST_RESP : ST_MEM;
      end
      ST_MEM: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_seed_q   <= '0;
      bit_ref_seed_q <= '0;
      index_mask_q   <= '0;
      masks_lo_q     <= '0;
      masks_hi_q     <= '0;
      size_log2_q    <= SIZE_LOG2_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VALUE_SEED:   value_seed_q   <= cfg_wdata_i;
        REG_BIT_REF_SEED: bit_ref_seed_q <= cfg_wdata_i;
        REG_INDEX_MASK:   index_mask_q   <= cfg_wdata_i[MASK_W-1:0];
        REG_MASKS_LO:     masks_lo_q     <= cfg_wdata_i;
        REG_MASKS_HI:     masks_hi_q     <= cfg_wdata_i;
        REG_SIZE_LOG2:    size_log2_q    <= cfg_wdata_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request capture and hashing.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_e'(s_axis_tuser);
      pos_q <= s_axis_tdata[POS_W-1:0];
      din_q <= s_axis_tdata[POS_W +: BYTE_W];
    end
    if (state_q == ST_MIX) begin
      vmask_q    <= vmix[BYTE_W-1:0];
      perm_q     <= pmix[PERM_W-1:0];
      base_q     <= (pos_aw ^ index_mask_q[AW-1:0]) & amask;
      raw_addr_q <= pos_aw & amask;
      err_q      <= pos_err;
    end
  end

  // Plane lanes.
  assign lane_ctl.en  = (state_q == ST_MEM);
  assign lane_ctl.we  = !is_read;
  assign lane_ctl.raw = is_raw;
  assign wbyte        = is_raw ? din_q : (din_q ^ vmask_q);
  assign lane_perm    = is_raw ? '0 : perm_q;

  for (genvar g = 0; g < PLANES; g++) begin : g_lane
    if (g < PLANES / 2) begin : g_lo
      assign plane_mask[g] = masks_lo_q[g*MASK_W +: MASK_W];
    end else begin : g_hi
      assign plane_mask[g] = masks_hi_q[(g - PLANES / 2)*MASK_W +: MASK_W];
    end

    bpsc_lane #(
      .DEPTH_LOG2 (DEPTH_LOG2),
      .LANE       (g)
    ) u_lane (
      .clk_i        (clk_i),
      .ctl_i        (lane_ctl),
      .base_i       (base_q),
      .raw_addr_i   (raw_addr_q),
      .amask_i      (amask),
      .plane_mask_i (plane_mask[g][AW-1:0]),
      .wbyte_i      (wbyte),
      .perm_i       (lane_perm),
      .rbit_o       (planes[g])
    );
  end

  bpsc_merge u_merge (
    .planes_i (planes),
    .raw_i    (is_raw),
    .perm_i   (perm_q),
    .vmask_i  (vmask_q),
    .byte_o   (merged)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_status_q <= err_q;
      out_data_q   <= (!err_q && is_read) ? merged : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  // A request always moves on to hashing in the next cycle.
  a_accept_to_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MIX)
    else $error("accepted request did not enter the hash step");

  // An error result never carries data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero data");

  // The plane memories are only touched for a request that passed the range check.
  a_mem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctl.en |-> $past(state_q) == ST_MIX && !err_q)
    else $error("plane memory access outside the access step");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RESP && m_axis_tvalid && !m_axis_tready |=> state_q == ST_RESP)
    else $error("result left the merge step while the output was blocked");

endmodule

`default_nettype wire
